[hdl/vat_pkg.sv]
// Shared types, constants and helpers of the vertex transform and normalize block.
package vat_pkg;

	localparam int NUM_REGS   = 6;
	localparam int IDX_W      = 3;
	localparam int REG_W      = 64;
	localparam int POS_W      = 32;
	localparam int DIR_W      = 16;
	localparam int VEC_W      = 50;
	localparam int FRONT_LAT  = 5;
	localparam int SQ_STEPS   = 25;
	localparam int DIV_STEPS  = 15;
	localparam int NORM_LAT   = 7 + SQ_STEPS + 1 + DIV_STEPS + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_ROW0_XY = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW0_ZW = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW1_XY = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROW1_ZW = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROW2_XY = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROW2_ZW = 3'd5;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_t;

	// Identity matrix after reset.
	localparam cfg_t CFG_RESET = {
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

	typedef struct packed {
		logic [2:0][POS_W-1:0] pos;
		logic [2:0][DIR_W-1:0] nrm;
		logic [2:0][DIR_W-1:0] tng;
	} vtx_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] pos;
		logic [2:0][VEC_W-1:0] vn;
		logic [2:0][VEC_W-1:0] vt;
		logic                  nrm_deg;
		logic                  tan_deg;
	} mid_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] pos;
		logic [2:0][DIR_W-1:0] nrm;
		logic [2:0][DIR_W-1:0] tng;
		logic                  nrm_deg;
		logic                  tan_deg;
	} res_t;

	// Matrix element M[i][j], signed Q16.16.
	function automatic logic signed [31:0] mat_elem(cfg_t c, int i, int j);
		logic [REG_W-1:0] r;
		r = c[2 * i + (j >> 1)];
		return signed'((j & 1) != 0 ? r[63:32] : r[31:0]);
	endfunction

	// Position of the highest set bit of a nonzero byte.
	function automatic logic [2:0] msb8(logic [7:0] b);
		logic [2:0] p;
		p = 3'd0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) p = 3'(k);
		end
		return p;
	endfunction

endpackage

[hdl/vat_front.sv]
// Front part: accepts vertices, applies the matrix and flags zero-length directions.
module vat_front (
	input  logic          clk,
	input  logic          arst_n,
	input  vat_pkg::cfg_t cfg,
	input  logic          push,
	output logic          full,
	input  vat_pkg::vtx_t vtx,
	output logic          word_valid,
	input  logic          word_ready,
	output vat_pkg::mid_t word
);
	import vat_pkg::*;

	localparam logic signed [51:0] SAT_HI = 52'sh0_0000_7FFF_FFFF;
	localparam logic signed [51:0] SAT_LO = -52'sh0_0000_8000_0000;
	localparam logic signed [65:0] RND_HALF = 66'sh8000;

	logic [FRONT_LAT-1:0] vld_q;
	logic en;

	vtx_t in_s1;
	logic signed [63:0] pp_s2[3][3];
	logic signed [47:0] np_s2[3][3];
	logic signed [47:0] tp_s2[3][3];
	logic signed [64:0] pa_s3[3];
	logic signed [63:0] pb_s3[3];
	logic signed [49:0] vn_s3[3];
	logic signed [49:0] vt_s3[3];
	logic signed [65:0] ps_s4[3];
	logic signed [49:0] vn_s4[3];
	logic signed [49:0] vt_s4[3];
	logic nd_s4, td_s4;
	logic [31:0] pos_s5[3];
	logic signed [49:0] vn_s5[3];
	logic signed [49:0] vt_s5[3];
	logic nd_s5, td_s5;
	logic signed [51:0] psum[3];

	// Advance when the last stage is empty or its word leaves.
	assign en = !vld_q[FRONT_LAT-1] || word_ready;
	assign full = !en;
	assign word_valid = vld_q[FRONT_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[FRONT_LAT-2:0], push};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum[i] = 52'(ps_s4[i] >>> 16) + 52'(mat_elem(cfg, i, 3));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= vtx;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s2[i][j] <= 64'(mat_elem(cfg, i, j)) * 64'(signed'(in_s1.pos[j]));
					np_s2[i][j] <= 48'(mat_elem(cfg, i, j)) * 48'(signed'(in_s1.nrm[j]));
					tp_s2[i][j] <= 48'(mat_elem(cfg, i, j)) * 48'(signed'(in_s1.tng[j]));
				end
				pa_s3[i] <= 65'(pp_s2[i][0]) + 65'(pp_s2[i][1]);
				pb_s3[i] <= pp_s2[i][2];
				vn_s3[i] <= 50'(np_s2[i][0]) + 50'(np_s2[i][1]) + 50'(np_s2[i][2]);
				vt_s3[i] <= 50'(tp_s2[i][0]) + 50'(tp_s2[i][1]) + 50'(tp_s2[i][2]);
				ps_s4[i] <= 66'(pa_s3[i]) + 66'(pb_s3[i]) + RND_HALF;
				vn_s4[i] <= vn_s3[i];
				vt_s4[i] <= vt_s3[i];
				if (psum[i] > SAT_HI) begin
					pos_s5[i] <= 32'h7FFF_FFFF;
				end else if (psum[i] < SAT_LO) begin
					pos_s5[i] <= 32'h8000_0000;
				end else begin
					pos_s5[i] <= psum[i][31:0];
				end
				vn_s5[i] <= vn_s4[i];
				vt_s5[i] <= vt_s4[i];
			end
			nd_s4 <= (vn_s3[0] == '0) && (vn_s3[1] == '0) && (vn_s3[2] == '0);
			td_s4 <= (vt_s3[0] == '0) && (vt_s3[1] == '0) && (vt_s3[2] == '0);
			nd_s5 <= nd_s4;
			td_s5 <= td_s4;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			word.pos[i] = pos_s5[i];
			word.vn[i]  = vn_s5[i];
			word.vt[i]  = vt_s5[i];
		end
		word.nrm_deg = nd_s5;
		word.tan_deg = td_s5;
	end

endmodule

[hdl/vat_fifo.sv]
// Short queue between the front and back parts.
module vat_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  vat_pkg::mid_t wdata,
	input  logic          pop,
	output logic          empty,
	output vat_pkg::mid_t rdata
);
	import vat_pkg::*;

	mid_t mem_q[FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

endmodule

[hdl/vat_norm.sv]
// Direction normalizer: scale, square root and per-component divide.
module vat_norm (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic [2:0][vat_pkg::VEC_W-1:0]          v,
	input  logic                                    deg,
	output logic [2:0][vat_pkg::DIR_W-1:0]          res,
	output logic                                    res_deg
);
	import vat_pkg::*;

	typedef struct packed {
		logic       deg;
		logic [2:0] neg;
	} sgn_t;

	logic [2:0][VEC_W-1:0] mag_s1, mag_s2, mag_s3, mag_s4;
	sgn_t sg_s1, sg_s2, sg_s3, sg_s4, sg_s5, sg_s6;
	logic [VEC_W-1:0] or_s2;
	logic [6:0] nz_s3;
	logic [6:0][2:0] p8_s3;
	logic [5:0] msb_s4;
	logic [5:0] msb_c;
	logic [2:0][23:0] sh_s5, sh_s6;
	logic [2:0][47:0] sq_s6;
	logic [55:0] or_pad;

	logic [28:0]      rt_rem[SQ_STEPS+1];
	logic [24:0]      rt_root[SQ_STEPS+1];
	logic [VEC_W-1:0] rt_l2[SQ_STEPS+1];
	logic [2:0][23:0] rt_mag[SQ_STEPS+1];
	sgn_t             rt_sg[SQ_STEPS+1];

	logic [2:0][39:0] dv_rem[DIV_STEPS+1];
	logic [2:0][14:0] dv_q[DIV_STEPS+1];
	logic [25:0]      dv_d[DIV_STEPS+1];
	sgn_t             dv_sg[DIV_STEPS+1];

	assign or_pad = {6'b0, or_s2};

	always_comb begin
		msb_c = '0;
		for (int c = 0; c < 7; c++) begin
			if (nz_s3[c]) msb_c = 6'(c * 8) + {3'b0, p8_s3[c]};
		end
	end

	// Magnitude, leading-one search, scaling so that the largest component lies in [2^23, 2^24), squares and their sum.
	always_ff @(posedge clk) begin
		if (en) begin
			sg_s1.deg <= deg;
			for (int i = 0; i < 3; i++) begin
				sg_s1.neg[i] <= v[i][VEC_W-1];
				mag_s1[i] <= v[i][VEC_W-1] ? -v[i] : v[i];
			end
			or_s2  <= mag_s1[0] | mag_s1[1] | mag_s1[2];
			mag_s2 <= mag_s1;
			sg_s2  <= sg_s1;
			for (int c = 0; c < 7; c++) begin
				nz_s3[c] <= |or_pad[8*c +: 8];
				p8_s3[c] <= msb8(or_pad[8*c +: 8]);
			end
			mag_s3 <= mag_s2;
			sg_s3  <= sg_s2;
			msb_s4 <= msb_c;
			mag_s4 <= mag_s3;
			sg_s4  <= sg_s3;
			for (int i = 0; i < 3; i++) begin
				if (msb_s4 > 6'd23) begin
					sh_s5[i] <= 24'(mag_s4[i] >> (msb_s4 - 6'd23));
				end else begin
					sh_s5[i] <= 24'(mag_s4[i] << (6'd23 - msb_s4));
				end
				sq_s6[i] <= 48'(sh_s5[i]) * 48'(sh_s5[i]);
			end
			sg_s5 <= sg_s4;
			sh_s6 <= sh_s5;
			sg_s6 <= sg_s5;
			rt_l2[0]   <= 50'(sq_s6[0]) + 50'(sq_s6[1]) + 50'(sq_s6[2]);
			rt_rem[0]  <= '0;
			rt_root[0] <= '0;
			rt_mag[0]  <= sh_s6;
			rt_sg[0]   <= sg_s6;
		end
	end

	// Square root, one result bit per stage.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [28:0] cand, trial;
		assign cand  = {rt_rem[k][26:0], rt_l2[k][2*(SQ_STEPS-1-k) +: 2]};
		assign trial = {2'b0, rt_root[k], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (cand >= trial) begin
					rt_rem[k+1]  <= cand - trial;
					rt_root[k+1] <= {rt_root[k][23:0], 1'b1};
				end else begin
					rt_rem[k+1]  <= cand;
					rt_root[k+1] <= {rt_root[k][23:0], 1'b0};
				end
				rt_l2[k+1]  <= rt_l2[k];
				rt_mag[k+1] <= rt_mag[k];
				rt_sg[k+1]  <= rt_sg[k];
			end
		end
	end

	// Rounded quotient (mag * 2^15 + r) / 2r, one bit per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= {1'b0, rt_mag[SQ_STEPS][i], 15'b0} + 40'(rt_root[SQ_STEPS]);
				dv_q[0][i]   <= '0;
			end
			dv_d[0]  <= {rt_root[SQ_STEPS], 1'b0};
			dv_sg[0] <= rt_sg[SQ_STEPS];
		end
	end

	for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
		logic [40:0] sub;
		assign sub = 41'(dv_d[s]) << (DIV_STEPS - 1 - s);
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if ({1'b0, dv_rem[s][i]} >= sub) begin
						dv_rem[s+1][i] <= dv_rem[s][i] - sub[39:0];
						dv_q[s+1][i]   <= dv_q[s][i] | 15'(1 << (DIV_STEPS - 1 - s));
					end else begin
						dv_rem[s+1][i] <= dv_rem[s][i];
						dv_q[s+1][i]   <= dv_q[s][i];
					end
				end
				dv_d[s+1]  <= dv_d[s];
				dv_sg[s+1] <= dv_sg[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_sg[DIV_STEPS].deg) begin
					res[i] <= '0;
				end else if (dv_sg[DIV_STEPS].neg[i]) begin
					res[i] <= -{1'b0, dv_q[DIV_STEPS][i]};
				end else begin
					res[i] <= {1'b0, dv_q[DIV_STEPS][i]};
				end
			end
			res_deg <= dv_sg[DIV_STEPS].deg;
		end
	end

endmodule

[hdl/vat_back.sv]
// Back part: normalizes both directions, delays the position, holds the result word.
module vat_back (
	input  logic          clk,
	input  logic          arst_n,
	input  vat_pkg::mid_t word,
	input  logic          word_valid,
	output logic          word_pop,
	output vat_pkg::res_t res,
	output logic          empty,
	input  logic          pop
);
	import vat_pkg::*;

	logic [NORM_LAT-1:0] vld_q;
	logic [2:0][POS_W-1:0] pos_dl_s[NORM_LAT];
	logic en;

	// Hold everything while the result word waits.
	assign en = !vld_q[NORM_LAT-1] || pop;
	assign word_pop = en && word_valid;
	assign empty = !vld_q[NORM_LAT-1];
	assign res.pos = pos_dl_s[NORM_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NORM_LAT-2:0], word_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_dl_s[0] <= word.pos;
			for (int k = 1; k < NORM_LAT; k++) begin
				pos_dl_s[k] <= pos_dl_s[k-1];
			end
		end
	end

	vat_norm u_nrm (
		.clk     (clk),
		.en      (en),
		.v       (word.vn),
		.deg     (word.nrm_deg),
		.res     (res.nrm),
		.res_deg (res.nrm_deg)
	);

	vat_norm u_tan (
		.clk     (clk),
		.en      (en),
		.v       (word.vt),
		.deg     (word.tan_deg),
		.res     (res.tng),
		.res_deg (res.tan_deg)
	);

endmodule

[hdl/vertex_affine_transform_normalize.sv]
// Top level of the vertex affine transform with direction normalization.
//
//  channel  | handshake          | word
//  ---------+--------------------+----------------------------------------------
//  input    | push / full        | pos_x..z Q16.16, nrm_x..z and tan_x..z Q2.14
//  result   | empty / pop        | out_pos_*, out_nrm_*, out_tan_*, degenerate flags
//  config   | wr_en, wr_idx      | wr_data, 64-bit matrix row halves
//
// One vertex per cycle sustained while the queue has room. A word passes
// the front (matrix multiply and sums), the queue between the parts and the
// back (scaling, 25-stage square root, 15-stage divide) before it is on the ports.
// Reset loads the identity matrix and empties all stages.
// A held result word stalls only the back part; the front keeps accepting
// until the four-entry queue between the two parts fills.
module vertex_affine_transform_normalize (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            pos_z,
	input  logic signed [15:0]            nrm_x,
	input  logic signed [15:0]            nrm_y,
	input  logic signed [15:0]            nrm_z,
	input  logic signed [15:0]            tan_x,
	input  logic signed [15:0]            tan_y,
	input  logic signed [15:0]            tan_z,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [31:0]            out_pos_x,
	output logic signed [31:0]            out_pos_y,
	output logic signed [31:0]            out_pos_z,
	output logic signed [15:0]            out_nrm_x,
	output logic signed [15:0]            out_nrm_y,
	output logic signed [15:0]            out_nrm_z,
	output logic signed [15:0]            out_tan_x,
	output logic signed [15:0]            out_tan_y,
	output logic signed [15:0]            out_tan_z,
	output logic                          normal_degenerate,
	output logic                          tangent_degenerate,
	input  logic                          wr_en,
	input  logic [vat_pkg::IDX_W-1:0]     wr_idx,
	input  logic [vat_pkg::REG_W-1:0]     wr_data
);
	import vat_pkg::*;

	cfg_t cfg_q;
	vtx_t vtx;
	mid_t f_word, q_word;
	res_t res;
	logic f_valid, q_full, q_empty, q_pop;

	// Matrix registers; indexes past the last register drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en && (wr_idx <= REG_ROW2_ZW)) begin
			cfg_q[wr_idx] <= wr_data;
		end
	end

	assign vtx.pos = {pos_z, pos_y, pos_x};
	assign vtx.nrm = {nrm_z, nrm_y, nrm_x};
	assign vtx.tng = {tan_z, tan_y, tan_x};

	// Front: accept, transform, flag zero-length directions.
	vat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.vtx        (vtx),
		.word_valid (f_valid),
		.word_ready (!q_full),
		.word       (f_word)
	);

	// Decoupling queue.
	vat_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.full   (q_full),
		.wdata  (f_word),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_word)
	);

	// Back: normalize and present the result word.
	vat_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word       (q_word),
		.word_valid (!q_empty),
		.word_pop   (q_pop),
		.res        (res),
		.empty      (empty),
		.pop        (pop)
	);

	assign out_pos_x = signed'(res.pos[0]);
	assign out_pos_y = signed'(res.pos[1]);
	assign out_pos_z = signed'(res.pos[2]);
	assign out_nrm_x = signed'(res.nrm[0]);
	assign out_nrm_y = signed'(res.nrm[1]);
	assign out_nrm_z = signed'(res.nrm[2]);
	assign out_tan_x = signed'(res.tng[0]);
	assign out_tan_y = signed'(res.tng[1]);
	assign out_tan_z = signed'(res.tng[2]);
	assign normal_degenerate  = res.nrm_deg;
	assign tangent_degenerate = res.tan_deg;

endmodule
